@@ src/csab_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csab_pkg;

  // Field widths of the pixel stream and the configuration registers.
  localparam int COORD_BITS = 12;
  localparam int DEPTH_BITS = 16;
  localparam int CHAN_BITS  = 8;

  // Fraction bits of the distance ratio and of alpha (Q1.16).
  localparam int FRAC_BITS = 16;

  // Derived datapath widths.
  localparam int EXT_BITS   = COORD_BITS + 2;     // signed box limits
  localparam int DIFF_BITS  = COORD_BITS + 1;     // signed offset from center
  localparam int SQ_BITS    = 2 * COORD_BITS;     // one square, and r squared
  localparam int D2_BITS    = SQ_BITS + 1;        // sum of two squares
  localparam int Q_BITS     = FRAC_BITS + 1;      // ratio, 0 to 1.0 inclusive
  localparam int DIV_STAGES = Q_BITS;             // one quotient bit per stage
  localparam int ALPHA_BITS = FRAC_BITS + 1;
  localparam int PROD_BITS  = CHAN_BITS + ALPHA_BITS;

  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = (DEPTH_BITS > COORD_BITS) ?
                                  ((DEPTH_BITS > CHAN_BITS) ? DEPTH_BITS : CHAN_BITS) :
                                  ((COORD_BITS > CHAN_BITS) ? COORD_BITS : CHAN_BITS);

  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CIRCLE_DEPTH = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_RED     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_GREEN   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_BLUE    = 3'd6;

  // One stage of the restoring divider, with the pixel data that rides along.
  typedef struct packed {
    logic                 valid;
    logic                 cov;
    logic [SQ_BITS-1:0]   rem;
    logic [Q_BITS-1:0]    q;
    logic [SQ_BITS-1:0]   r2;
    logic [CHAN_BITS-1:0] old_r;
    logic [CHAN_BITS-1:0] old_g;
    logic [CHAN_BITS-1:0] old_b;
  } div_stage_t;

  // One finished result.
  typedef struct packed {
    logic                 write;
    logic [CHAN_BITS-1:0] r;
    logic [CHAN_BITS-1:0] g;
    logic [CHAN_BITS-1:0] b;
  } pix_out_t;

  // Produce one more quotient bit: shift the remainder and subtract the
  // divisor when it fits.
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t         n;
    logic [SQ_BITS:0]   shifted;
    logic [SQ_BITS:0]   diff;
    logic               fits;
    n       = s;
    shifted = {s.rem, 1'b0};
    diff    = shifted - {1'b0, s.r2};
    fits    = (shifted >= {1'b0, s.r2});
    n.rem   = fits ? diff[SQ_BITS-1:0] : shifted[SQ_BITS-1:0];
    n.q     = {s.q[Q_BITS-2:0], fits};
    return n;
  endfunction

endpackage

`default_nettype wire

@@ src/circle_splat_alpha_blend.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A pixel passes through stages 1 to 3, the divider stages, M1, M2 and the output register.
// One pixel per clock while the skid register is empty; the 17-stage quotient divider is fully pipelined.
// A held result parks in a one-entry skid register and the pipeline freezes only when it is full.
// Reset (rst, synchronous) clears the circle registers to zero and empties every pipeline stage.
// The configuration port always accepts; the user must issue writes only while no pixel is in flight (not enforced).
module circle_splat_alpha_blend (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [csab_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire  [csab_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [csab_pkg::COORD_BITS-1:0]      pixel_x,
  input  wire  [csab_pkg::COORD_BITS-1:0]      pixel_y,
  input  wire  [csab_pkg::CHAN_BITS-1:0]       old_red,
  input  wire  [csab_pkg::CHAN_BITS-1:0]       old_green,
  input  wire  [csab_pkg::CHAN_BITS-1:0]       old_blue,
  input  wire  [csab_pkg::DEPTH_BITS-1:0]      old_depth,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 write_pixel,
  output logic [csab_pkg::CHAN_BITS-1:0]       new_red,
  output logic [csab_pkg::CHAN_BITS-1:0]       new_green,
  output logic [csab_pkg::CHAN_BITS-1:0]       new_blue
);

  import csab_pkg::*;

  // Configuration registers.
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-1:0] radius;
  logic [DEPTH_BITS-1:0] circle_depth;
  logic [CHAN_BITS-1:0]  fill_red;
  logic [CHAN_BITS-1:0]  fill_green;
  logic [CHAN_BITS-1:0]  fill_blue;

  // Pipeline advance; low only while the skid register holds a result.
  logic en;
  logic skid_valid;

  // Stage 1: box and depth tests, offsets from the center.
  logic                        s1_valid;
  logic                        s1_hit;
  logic signed [DIFF_BITS-1:0] s1_dx;
  logic signed [DIFF_BITS-1:0] s1_dy;
  logic [CHAN_BITS-1:0]        s1_old_r;
  logic [CHAN_BITS-1:0]        s1_old_g;
  logic [CHAN_BITS-1:0]        s1_old_b;

  // Stage 2: squares.
  logic                 s2_valid;
  logic                 s2_hit;
  logic [SQ_BITS-1:0]   s2_sqx;
  logic [SQ_BITS-1:0]   s2_sqy;
  logic [SQ_BITS-1:0]   s2_r2;
  logic [CHAN_BITS-1:0] s2_old_r;
  logic [CHAN_BITS-1:0] s2_old_g;
  logic [CHAN_BITS-1:0] s2_old_b;

  // Stage 3: distance test and divider operand.
  logic                 s3_valid;
  logic                 s3_cov;
  logic [SQ_BITS-1:0]   s3_num;
  logic [SQ_BITS-1:0]   s3_r2;
  logic [CHAN_BITS-1:0] s3_old_r;
  logic [CHAN_BITS-1:0] s3_old_g;
  logic [CHAN_BITS-1:0] s3_old_b;

  // Divider stages.
  div_stage_t div_pipe [DIV_STAGES];
  div_stage_t div_next [DIV_STAGES];

  // Stage M1: squared ratio, which is one minus alpha.
  logic                  m1_valid;
  logic                  m1_cov;
  logic [ALPHA_BITS-1:0] m1_beta;
  logic [CHAN_BITS-1:0]  m1_old_r;
  logic [CHAN_BITS-1:0]  m1_old_g;
  logic [CHAN_BITS-1:0]  m1_old_b;

  // Stage M2: blend products.
  logic                 m2_valid;
  logic                 m2_cov;
  logic [PROD_BITS-1:0] m2_old_pr;
  logic [PROD_BITS-1:0] m2_old_pg;
  logic [PROD_BITS-1:0] m2_old_pb;
  logic [PROD_BITS-1:0] m2_fill_pr;
  logic [PROD_BITS-1:0] m2_fill_pg;
  logic [PROD_BITS-1:0] m2_fill_pb;
  logic [CHAN_BITS-1:0] m2_old_r;
  logic [CHAN_BITS-1:0] m2_old_g;
  logic [CHAN_BITS-1:0] m2_old_b;

  pix_out_t result;
  pix_out_t skid;

  // Configuration writes; indexes past the last register are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      radius       <= '0;
      circle_depth <= '0;
      fill_red     <= '0;
      fill_green   <= '0;
      fill_blue    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:     center_x     <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Y:     center_y     <= cfg_data[COORD_BITS-1:0];
        REG_RADIUS:       radius       <= cfg_data[COORD_BITS-1:0];
        REG_CIRCLE_DEPTH: circle_depth <= cfg_data[DEPTH_BITS-1:0];
        REG_FILL_RED:     fill_red     <= cfg_data[CHAN_BITS-1:0];
        REG_FILL_GREEN:   fill_green   <= cfg_data[CHAN_BITS-1:0];
        REG_FILL_BLUE:    fill_blue    <= cfg_data[CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !skid_valid;
  assign in_ready = en;

  // Half-open box test in signed arithmetic, since the box may leave the frame.
  logic signed [EXT_BITS-1:0]  px_ext;
  logic signed [EXT_BITS-1:0]  py_ext;
  logic signed [EXT_BITS-1:0]  lo_x;
  logic signed [EXT_BITS-1:0]  hi_x;
  logic signed [EXT_BITS-1:0]  lo_y;
  logic signed [EXT_BITS-1:0]  hi_y;
  logic                        in_box;
  logic                        depth_ok;
  logic signed [DIFF_BITS-1:0] dx;
  logic signed [DIFF_BITS-1:0] dy;

  always_comb begin
    px_ext   = signed'({2'b00, pixel_x});
    py_ext   = signed'({2'b00, pixel_y});
    lo_x     = signed'({2'b00, center_x}) - signed'({2'b00, radius});
    hi_x     = signed'({2'b00, center_x}) + signed'({2'b00, radius});
    lo_y     = signed'({2'b00, center_y}) - signed'({2'b00, radius});
    hi_y     = signed'({2'b00, center_y}) + signed'({2'b00, radius});
    in_box   = (radius != '0) && (px_ext >= lo_x) && (px_ext < hi_x) &&
               (py_ext >= lo_y) && (py_ext < hi_y);
    depth_ok = (old_depth < circle_depth);
    dx       = signed'({1'b0, pixel_x}) - signed'({1'b0, center_x});
    dy       = signed'({1'b0, pixel_y}) - signed'({1'b0, center_y});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s1_hit   <= in_box && depth_ok;
      s1_dx    <= dx;
      s1_dy    <= dy;
      s1_old_r <= old_red;
      s1_old_g <= old_green;
      s1_old_b <= old_blue;
    end
  end

  // Squares of the offsets and of the radius.
  logic signed [2*DIFF_BITS-1:0] prod_x;
  logic signed [2*DIFF_BITS-1:0] prod_y;
  logic [SQ_BITS-1:0]            prod_r;

  always_comb begin
    prod_x = s1_dx * s1_dx;
    prod_y = s1_dy * s1_dy;
    prod_r = radius * radius;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s2_hit   <= s1_hit;
      s2_sqx   <= prod_x[SQ_BITS-1:0];
      s2_sqy   <= prod_y[SQ_BITS-1:0];
      s2_r2    <= prod_r;
      s2_old_r <= s1_old_r;
      s2_old_g <= s1_old_g;
      s2_old_b <= s1_old_b;
    end
  end

  // Distance test; an uncovered pixel feeds zero to the divider.
  logic [D2_BITS-1:0] d2;
  logic               cov;

  always_comb begin
    d2  = {1'b0, s2_sqx} + {1'b0, s2_sqy};
    cov = s2_hit && (d2 <= {1'b0, s2_r2});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
      s3_cov   <= cov;
      s3_num   <= cov ? d2[SQ_BITS-1:0] : '0;
      s3_r2    <= s2_r2;
      s3_old_r <= s2_old_r;
      s3_old_g <= s2_old_g;
      s3_old_b <= s2_old_b;
    end
  end

  // Restoring divider for d2 * 2^16 / r2. The top bit only shows whether
  // d2 equals r2, since a covered pixel has d2 at most r2.
  logic first_fits;

  always_comb begin
    first_fits          = (s3_num >= s3_r2);
    div_next[0].valid   = s3_valid;
    div_next[0].cov     = s3_cov;
    div_next[0].rem     = first_fits ? (s3_num - s3_r2) : s3_num;
    div_next[0].q       = {{(Q_BITS-1){1'b0}}, first_fits};
    div_next[0].r2      = s3_r2;
    div_next[0].old_r   = s3_old_r;
    div_next[0].old_g   = s3_old_g;
    div_next[0].old_b   = s3_old_b;
    for (int k = 1; k < DIV_STAGES; k++) begin
      div_next[k] = div_step(div_pipe[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        div_pipe[k].valid <= 1'b0;
      end
    end else if (en) begin
      div_pipe <= div_next;
    end
  end

  // Square the ratio; bits 2*FRAC_BITS down to FRAC_BITS are one minus alpha.
  logic [2*Q_BITS-1:0] q_sq;

  assign q_sq = div_pipe[DIV_STAGES-1].q * div_pipe[DIV_STAGES-1].q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= div_pipe[DIV_STAGES-1].valid;
      m1_cov   <= div_pipe[DIV_STAGES-1].cov;
      m1_beta  <= q_sq[2*FRAC_BITS:FRAC_BITS];
      m1_old_r <= div_pipe[DIV_STAGES-1].old_r;
      m1_old_g <= div_pipe[DIV_STAGES-1].old_g;
      m1_old_b <= div_pipe[DIV_STAGES-1].old_b;
    end
  end

  // Blend products: old color weighted by one minus alpha, fill by alpha.
  logic [ALPHA_BITS-1:0] alpha;

  assign alpha = ALPHA_ONE - m1_beta;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid   <= m1_valid;
      m2_cov     <= m1_cov;
      m2_old_pr  <= m1_old_r * m1_beta;
      m2_old_pg  <= m1_old_g * m1_beta;
      m2_old_pb  <= m1_old_b * m1_beta;
      m2_fill_pr <= fill_red * alpha;
      m2_fill_pg <= fill_green * alpha;
      m2_fill_pb <= fill_blue * alpha;
      m2_old_r   <= m1_old_r;
      m2_old_g   <= m1_old_g;
      m2_old_b   <= m1_old_b;
    end
  end

  // Final sums, truncated; an unwritten pixel keeps its stored color.
  logic [PROD_BITS-1:0] sum_r;
  logic [PROD_BITS-1:0] sum_g;
  logic [PROD_BITS-1:0] sum_b;

  always_comb begin
    sum_r        = m2_old_pr + m2_fill_pr;
    sum_g        = m2_old_pg + m2_fill_pg;
    sum_b        = m2_old_pb + m2_fill_pb;
    result.write = m2_cov;
    result.r     = m2_cov ? sum_r[FRAC_BITS+CHAN_BITS-1:FRAC_BITS] : m2_old_r;
    result.g     = m2_cov ? sum_g[FRAC_BITS+CHAN_BITS-1:FRAC_BITS] : m2_old_g;
    result.b     = m2_cov ? sum_b[FRAC_BITS+CHAN_BITS-1:FRAC_BITS] : m2_old_b;
  end

  // Output register with a one-entry skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (m2_valid && en) begin
        skid_valid <= 1'b1;
        skid       <= result;
      end
    end else if (skid_valid) begin
      out_valid   <= 1'b1;
      skid_valid  <= 1'b0;
      write_pixel <= skid.write;
      new_red     <= skid.r;
      new_green   <= skid.g;
      new_blue    <= skid.b;
    end else if (m2_valid && en) begin
      out_valid   <= 1'b1;
      write_pixel <= result.write;
      new_red     <= result.r;
      new_green   <= result.g;
      new_blue    <= result.b;
    end else begin
      out_valid <= 1'b0;
    end
  end

  // The skid register is only filled behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register is empty");

  // A covered pixel's ratio never exceeds one.
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    (div_pipe[DIV_STAGES-1].valid && div_pipe[DIV_STAGES-1].cov) |->
      (div_pipe[DIV_STAGES-1].q <= {1'b1, {FRAC_BITS{1'b0}}}))
    else $error("distance ratio above one for a covered pixel");

  // A frozen pipeline keeps its last stage.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> ($stable(m2_valid) && $stable(m2_fill_pr) && $stable(m2_cov)))
    else $error("pipeline moved while stalled");

  // A skid fill happens exactly when a result arrives behind a held output.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && m2_valid && in_ready) |=> skid_valid)
    else $error("result arriving behind a held output was not parked");

endmodule

`default_nettype wire
